/* sv/aip_pkg.sv */
`timescale 1ns / 1ps

package aip_pkg;

    // Parse phase of the current string
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_BODY   = 3'd3,
        PH_TRAIL  = 3'd4
    } aip_phase_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } aip_base_t;

    // Error codes as shown on error_code
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LOWF  = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_KI    = 8'h6B;  // k
    localparam logic [7:0] CH_K     = 8'h4B;  // K
    localparam logic [7:0] CH_MI    = 8'h6D;  // m
    localparam logic [7:0] CH_M     = 8'h4D;  // M
    localparam logic [7:0] CH_GI    = 8'h67;  // g
    localparam logic [7:0] CH_G     = 8'h47;  // G

    // Magnitude limits
    localparam logic [63:0] MAX_POS = 64'hFFFF_FFFF;
    localparam logic [63:0] MAX_NEG = 64'h8000_0000;

    // Suffix factors
    localparam logic [31:0] F_KI = 32'd1024;
    localparam logic [31:0] F_K  = 32'd1000;
    localparam logic [31:0] F_MI = 32'd1048576;
    localparam logic [31:0] F_M  = 32'd1000000;
    localparam logic [31:0] F_GI = 32'd1073741824;
    localparam logic [31:0] F_G  = 32'd1000000000;

    // Largest magnitude that a factor may scale without leaving range
    localparam logic [31:0] LP_KI = 32'(MAX_POS / 64'(F_KI));
    localparam logic [31:0] LP_K  = 32'(MAX_POS / 64'(F_K));
    localparam logic [31:0] LP_MI = 32'(MAX_POS / 64'(F_MI));
    localparam logic [31:0] LP_M  = 32'(MAX_POS / 64'(F_M));
    localparam logic [31:0] LP_GI = 32'(MAX_POS / 64'(F_GI));
    localparam logic [31:0] LP_G  = 32'(MAX_POS / 64'(F_G));
    localparam logic [31:0] LN_KI = 32'(MAX_NEG / 64'(F_KI));
    localparam logic [31:0] LN_K  = 32'(MAX_NEG / 64'(F_K));
    localparam logic [31:0] LN_MI = 32'(MAX_NEG / 64'(F_MI));
    localparam logic [31:0] LN_M  = 32'(MAX_NEG / 64'(F_M));
    localparam logic [31:0] LN_GI = 32'(MAX_NEG / 64'(F_GI));
    localparam logic [31:0] LN_G  = 32'(MAX_NEG / 64'(F_G));

    // Parser state, also handed to the finish stage on the last word
    typedef struct packed {
        aip_phase_t  phase;
        logic        negative;
        aip_base_t   base;
        logic [31:0] acc;
        logic [1:0]  err;
        logic [7:0]  held_char;
        logic        held_valid;
        logic        body_seen;
    } aip_state_t;

    localparam aip_state_t STATE_RESET = '{
        phase:      PH_LEAD,
        negative:   1'b0,
        base:       BASE_DEC,
        acc:        32'd0,
        err:        ERR_OK,
        held_char:  8'd0,
        held_valid: 1'b0,
        body_seen:  1'b0
    };

    typedef struct packed {
        logic [1:0]  err;
        logic [31:0] acc;
    } aip_digit_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] factor;
        logic [31:0] lim_pos;
        logic [31:0] lim_neg;
    } aip_suffix_t;

    function automatic logic aip_is_space(logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
    endfunction

    // Fold one digit into the magnitude, with digit and range checks
    function automatic aip_digit_t aip_take_digit(logic [31:0] acc, aip_base_t base,
                                                  logic neg, logic [7:0] c);
        logic [7:0]  lc;
        logic [4:0]  d;
        logic        dv;
        logic [4:0]  r;
        logic [35:0] nv;
        logic [35:0] lim;
        aip_digit_t  res;
        res.err = ERR_OK;
        res.acc = acc;
        lc = ((c >= CH_UA) && (c <= CH_UZ)) ? (c + 8'd32) : c;
        dv = 1'b1;
        d  = 5'd0;
        if ((lc >= CH_0) && (lc <= CH_9)) begin
            d = 5'(lc - CH_0);
        end
        else if ((lc >= CH_LA) && (lc <= CH_LOWF)) begin
            d = 5'(lc - CH_LA) + 5'd10;
        end
        else begin
            dv = 1'b0;
        end
        case (base)
            BASE_OCT:
            begin
                r  = 5'd8;
                nv = {1'b0, acc, 3'b000};
            end
            BASE_HEX:
            begin
                r  = 5'd16;
                nv = {acc, 4'b0000};
            end
            default:
            begin
                r  = 5'd10;
                nv = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
            end
        endcase
        nv  = nv + 36'(d);
        lim = neg ? 36'(MAX_NEG) : 36'(MAX_POS);
        if (!dv || (d >= r)) begin
            res.err = ERR_FORMAT;
        end
        else if (nv > lim) begin
            res.err = ERR_RANGE;
        end
        else begin
            res.acc = nv[31:0];
        end
        return res;
    endfunction

    // Decode a size suffix character
    function automatic aip_suffix_t aip_suffix(logic [7:0] c);
        aip_suffix_t s;
        s = '{hit: 1'b1, factor: F_KI, lim_pos: LP_KI, lim_neg: LN_KI};
        case (c)
            CH_KI:   s = '{hit: 1'b1, factor: F_KI, lim_pos: LP_KI, lim_neg: LN_KI};
            CH_K:    s = '{hit: 1'b1, factor: F_K,  lim_pos: LP_K,  lim_neg: LN_K};
            CH_MI:   s = '{hit: 1'b1, factor: F_MI, lim_pos: LP_MI, lim_neg: LN_MI};
            CH_M:    s = '{hit: 1'b1, factor: F_M,  lim_pos: LP_M,  lim_neg: LN_M};
            CH_GI:   s = '{hit: 1'b1, factor: F_GI, lim_pos: LP_GI, lim_neg: LN_GI};
            CH_G:    s = '{hit: 1'b1, factor: F_G,  lim_pos: LP_G,  lim_neg: LN_G};
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

/* sv/ascii_integer_parser_core.sv */
`timescale 1ns / 1ps
// A word's result moves from the input register into the finish snapshot and then into
// the result register once the last character is accepted.
// Throughput: one character per cycle except under the hold below; the parser state feeds back through one register.
// Output backpressure holds the input only while a last character waits on a full finish stage.
// Reset (rst_n low, asynchronous) empties all stages and returns the parser to
// leading whitespace with a cleared value and no error.

module ascii_integer_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] value,
    output logic [1:0]  error_code
);
    import aip_pkg::*;

    logic       fin_free;
    logic       snap_load;
    aip_state_t snap;

    aip_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .is_last    (is_last),
        .fin_free   (fin_free),
        .snap_load  (snap_load),
        .snap       (snap)
    );

    aip_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_load    (snap_load),
        .snap         (snap),
        .fin_free     (fin_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .error_code   (error_code)
    );

endmodule

/* sv/aip_scan.sv */
`timescale 1ns / 1ps

module aip_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  logic [7:0]          char_code,
    input  logic                is_last,
    input  logic                fin_free,
    output logic                snap_load,
    output aip_pkg::aip_state_t snap
);
    import aip_pkg::*;

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       fire;
    logic       ws;
    aip_digit_t td;
    aip_state_t state_reg;
    aip_state_t state_next;

    // Consume the held word unless a last word waits on the finish stage
    assign fire       = in_valid_reg && (!last_reg || fin_free);
    assign char_ready = !in_valid_reg || fire;
    assign snap_load  = fire && last_reg;
    assign snap       = state_next;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_valid && char_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
    end

    // Advance the parser by one character
    always_comb
    begin
        state_next = state_reg;
        ws = aip_is_space(char_reg);
        td = aip_take_digit(state_reg.acc, state_reg.base, state_reg.negative,
                            state_reg.held_char);
        if (state_reg.err == ERR_OK)
        begin
            unique case (state_reg.phase)
                PH_LEAD:
                begin
                    if (!ws)
                    begin
                        if (char_reg == CH_PLUS)
                        begin
                            state_next.phase = PH_SIGNED;
                        end
                        else if (char_reg == CH_MINUS)
                        begin
                            state_next.negative = 1'b1;
                            state_next.phase    = PH_SIGNED;
                        end
                        else if (char_reg == CH_0)
                        begin
                            state_next.phase = PH_ZERO;
                        end
                        else
                        begin
                            state_next.base       = BASE_DEC;
                            state_next.phase      = PH_BODY;
                            state_next.held_char  = char_reg;
                            state_next.held_valid = 1'b1;
                            state_next.body_seen  = 1'b1;
                        end
                    end
                end
                PH_SIGNED:
                begin
                    if (ws)
                    begin
                        state_next.err = ERR_FORMAT;
                    end
                    else if (char_reg == CH_0)
                    begin
                        state_next.phase = PH_ZERO;
                    end
                    else
                    begin
                        state_next.base       = BASE_DEC;
                        state_next.phase      = PH_BODY;
                        state_next.held_char  = char_reg;
                        state_next.held_valid = 1'b1;
                        state_next.body_seen  = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (ws)
                    begin
                        state_next.phase = PH_TRAIL;
                    end
                    else if (char_reg == CH_X)
                    begin
                        state_next.base  = BASE_HEX;
                        state_next.phase = PH_BODY;
                    end
                    else
                    begin
                        state_next.base       = BASE_OCT;
                        state_next.phase      = PH_BODY;
                        state_next.held_char  = char_reg;
                        state_next.held_valid = 1'b1;
                        state_next.body_seen  = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (ws)
                    begin
                        if (!state_reg.body_seen)
                        begin
                            state_next.err = ERR_FORMAT;
                        end
                        else
                        begin
                            state_next.phase = PH_TRAIL;
                        end
                    end
                    else if (state_reg.held_valid && (td.err != ERR_OK))
                    begin
                        state_next.err = td.err;
                    end
                    else
                    begin
                        // Retire the held digit, hold the new one as a possible suffix
                        if (state_reg.held_valid)
                        begin
                            state_next.acc = td.acc;
                        end
                        state_next.held_char  = char_reg;
                        state_next.held_valid = 1'b1;
                        state_next.body_seen  = 1'b1;
                    end
                end
                PH_TRAIL:
                begin
                    if (!ws)
                    begin
                        if (state_reg.held_valid && (td.err != ERR_OK))
                        begin
                            state_next.err = td.err;
                        end
                        else
                        begin
                            state_next.err = ERR_FORMAT;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // Parser state; drop back to reset after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= last_reg ? STATE_RESET : state_next;
        end
    end

endmodule

/* sv/aip_finish.sv */
`timescale 1ns / 1ps

module aip_finish (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                snap_load,
    input  aip_pkg::aip_state_t snap,
    output logic                fin_free,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [31:0]         value,
    output logic [1:0]          error_code
);
    import aip_pkg::*;

    logic        fin_valid_reg;
    aip_state_t  snap_reg;
    logic        can_out;
    aip_digit_t  td;
    aip_suffix_t sf;
    logic [31:0] lim;
    logic [31:0] mag;
    logic [1:0]  err;
    logic [31:0] value_next;
    logic        result_valid_reg;
    logic [31:0] value_reg;
    logic [1:0]  error_code_reg;

    assign can_out  = !result_valid_reg || result_ready;
    assign fin_free = !fin_valid_reg || can_out;

    // Snapshot of the parser after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (snap_load)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (can_out)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg <= snap;
        end
    end

    // Close the string: last digit or suffix scaling, then the sign
    always_comb
    begin
        td  = aip_take_digit(snap_reg.acc, snap_reg.base, snap_reg.negative,
                             snap_reg.held_char);
        sf  = aip_suffix(snap_reg.held_char);
        lim = snap_reg.negative ? sf.lim_neg : sf.lim_pos;
        err = snap_reg.err;
        mag = snap_reg.acc;
        if (snap_reg.err == ERR_OK)
        begin
            if ((snap_reg.phase == PH_LEAD) || (snap_reg.phase == PH_SIGNED))
            begin
                err = ERR_FORMAT;
            end
            else if ((snap_reg.phase == PH_ZERO) || !snap_reg.held_valid)
            begin
                if ((snap_reg.phase == PH_BODY) && !snap_reg.body_seen)
                begin
                    err = ERR_FORMAT;
                end
                else
                begin
                    mag = 32'd0;
                end
            end
            else if ((snap_reg.base == BASE_DEC) && sf.hit)
            begin
                if (snap_reg.acc > lim)
                begin
                    err = ERR_RANGE;
                end
                else
                begin
                    mag = snap_reg.acc * sf.factor;
                end
            end
            else
            begin
                err = td.err;
                mag = td.acc;
            end
        end
        if (err != ERR_OK)
        begin
            value_next = 32'd0;
        end
        else if (snap_reg.negative)
        begin
            value_next = 32'd0 - mag;
        end
        else
        begin
            value_next = mag;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fin_valid_reg && can_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid_reg && can_out)
        begin
            value_reg      <= value_next;
            error_code_reg <= err;
        end
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign error_code   = error_code_reg;

endmodule

/* sv/aip_checker.sv */
`timescale 1ns / 1ps

module aip_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        char_valid,
    input logic        char_ready,
    input logic [7:0]  char_code,
    input logic        is_last,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] value,
    input logic [1:0]  error_code
);
    import aip_pkg::*;

    // Hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(value) && $stable(error_code))
        else $error("result word changed while stalled");

    // Zero value on any error
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (error_code != ERR_OK) |-> (value == 32'd0))
        else $error("nonzero value with error");

    // Only defined error codes
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (error_code == ERR_OK) || (error_code == ERR_FORMAT) ||
                         (error_code == ERR_RANGE))
        else $error("undefined error code");

    // An accepted word that is not last never blocks the next cycle's input
    a_no_stall_mid: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready && !is_last |=> char_ready)
        else $error("input stalled behind a non-final character");

endmodule

bind ascii_integer_parser_core aip_checker u_aip_checker (.*);

/* verif/aip_number_checker.sv */
`timescale 1ns / 1ps

module aip_number_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [31:0] value,
    input  logic [1:0]  error_code,
    output int          fail_count,
    output int          results_due,
    output int          results_checked
);
    import aip_pkg::*;

    typedef struct packed {
        logic [31:0] num;
        logic [1:0]  code;
    } parse_result_t;

    // Parsed numbers still owed by the block, oldest first
    parse_result_t due_numbers[$];

    // Shadow parse state
    aip_phase_t  scan_phase;
    logic        minus_seen;
    aip_base_t   scan_base;
    logic [31:0] mag;
    logic [1:0]  first_err;
    logic [7:0]  pend_char;
    logic        pend_ok;
    logic        digits_seen;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
    endfunction

    function automatic logic [63:0] size_factor(input logic [7:0] c);
        case (c)
            CH_KI:   return 64'(F_KI);
            CH_K:    return 64'(F_K);
            CH_MI:   return 64'(F_MI);
            CH_M:    return 64'(F_M);
            CH_GI:   return 64'(F_GI);
            CH_G:    return 64'(F_G);
            default: return 64'd1;
        endcase
    endfunction

    function automatic logic [63:0] mag_ceiling();
        return minus_seen ? MAX_NEG : MAX_POS;
    endfunction

    task automatic clear_parse();
        scan_phase  = PH_LEAD;
        minus_seen  = 1'b0;
        scan_base   = BASE_DEC;
        mag         = '0;
        first_err   = ERR_OK;
        pend_char   = '0;
        pend_ok     = 1'b0;
        digits_seen = 1'b0;
    endtask

    // Fold one digit into the magnitude; latch a format or range error
    task automatic fold_digit(input logic [7:0] c);
        logic [7:0]  lc;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] nv;
        logic        ok;
        lc = c;
        d  = 64'd0;
        ok = 1'b1;
        if ((c >= CH_UA) && (c <= CH_UZ))
        begin
            lc = c + 8'd32;
        end
        if ((lc >= CH_0) && (lc <= CH_9))
        begin
            d = 64'(lc - CH_0);
        end
        else if ((lc >= CH_LA) && (lc <= CH_LOWF))
        begin
            d = 64'(lc - CH_LA) + 64'd10;
        end
        else
        begin
            ok = 1'b0;
        end
        case (scan_base)
            BASE_OCT: r = 64'd8;
            BASE_HEX: r = 64'd16;
            default:  r = 64'd10;
        endcase
        if (!ok || (d >= r))
        begin
            first_err = ERR_FORMAT;
        end
        else
        begin
            nv = {32'd0, mag} * r + d;
            if (nv > mag_ceiling())
            begin
                first_err = ERR_RANGE;
            end
            else
            begin
                mag = nv[31:0];
            end
        end
    endtask

    task automatic open_body(input logic [7:0] c, input aip_base_t b);
        scan_base   = b;
        scan_phase  = PH_BODY;
        pend_char   = c;
        pend_ok     = 1'b1;
        digits_seen = 1'b1;
    endtask

    // Advance the parse by one character
    task automatic absorb_char(input logic [7:0] c);
        logic ws;
        ws = is_blank(c);
        case (scan_phase)
            PH_LEAD:
            begin
                if (!ws)
                begin
                    if (c == CH_PLUS)
                    begin
                        scan_phase = PH_SIGNED;
                    end
                    else if (c == CH_MINUS)
                    begin
                        minus_seen = 1'b1;
                        scan_phase = PH_SIGNED;
                    end
                    else if (c == CH_0)
                    begin
                        scan_phase = PH_ZERO;
                    end
                    else
                    begin
                        open_body(c, BASE_DEC);
                    end
                end
            end
            PH_SIGNED:
            begin
                if (ws)
                begin
                    first_err = ERR_FORMAT;
                end
                else if (c == CH_0)
                begin
                    scan_phase = PH_ZERO;
                end
                else
                begin
                    open_body(c, BASE_DEC);
                end
            end
            PH_ZERO:
            begin
                if (ws)
                begin
                    scan_phase = PH_TRAIL;
                end
                else if (c == CH_X)
                begin
                    scan_base  = BASE_HEX;
                    scan_phase = PH_BODY;
                end
                else
                begin
                    open_body(c, BASE_OCT);
                end
            end
            PH_BODY:
            begin
                if (ws)
                begin
                    if (!digits_seen)
                    begin
                        first_err = ERR_FORMAT;
                    end
                    else
                    begin
                        scan_phase = PH_TRAIL;
                    end
                end
                else
                begin
                    // the held character turns out not to be a suffix
                    if (pend_ok)
                    begin
                        fold_digit(pend_char);
                    end
                    if (first_err == ERR_OK)
                    begin
                        pend_char   = c;
                        pend_ok     = 1'b1;
                        digits_seen = 1'b1;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (!ws)
                begin
                    if (pend_ok)
                    begin
                        fold_digit(pend_char);
                    end
                    if (first_err == ERR_OK)
                    begin
                        first_err = ERR_FORMAT;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Resolve the held character and produce the number for the string
    task automatic close_string(output parse_result_t res);
        logic [63:0] f;
        logic [63:0] nv;
        if (first_err == ERR_OK)
        begin
            if ((scan_phase == PH_LEAD) || (scan_phase == PH_SIGNED))
            begin
                first_err = ERR_FORMAT;
            end
            else if ((scan_phase == PH_ZERO) || !pend_ok)
            begin
                if ((scan_phase == PH_BODY) && !digits_seen)
                begin
                    first_err = ERR_FORMAT;
                end
                else
                begin
                    mag = '0;
                end
            end
            else
            begin
                f = (scan_base == BASE_DEC) ? size_factor(pend_char) : 64'd1;
                if (f == 64'd1)
                begin
                    fold_digit(pend_char);
                end
                else
                begin
                    nv = {32'd0, mag} * f;
                    if (nv > mag_ceiling())
                    begin
                        first_err = ERR_RANGE;
                    end
                    else
                    begin
                        mag = nv[31:0];
                    end
                end
            end
        end
        res.code = first_err;
        if (first_err != ERR_OK)
        begin
            res.num = '0;
        end
        else
        begin
            res.num = minus_seen ? (32'd0 - mag) : mag;
        end
        clear_parse();
    endtask

    // Compare results leaving the block, then track characters going in
    always @(posedge clk)
    begin : track
        parse_result_t want;
        if (!rst_n)
        begin
            clear_parse();
            due_numbers.delete();
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_numbers.size() == 0)
                begin
                    $error("result word with nothing expected: value %h, error_code %0d",
                           value, error_code);
                    fail_count++;
                end
                else
                begin
                    want = due_numbers.pop_front();
                    results_checked++;
                    if (value !== want.num)
                    begin
                        $error("value mismatch: expected %h, actual %h", want.num, value);
                        fail_count++;
                    end
                    if (error_code !== want.code)
                    begin
                        $error("error_code mismatch: expected %0d, actual %0d",
                               want.code, error_code);
                        fail_count++;
                    end
                end
            end
            if (char_valid && char_ready)
            begin
                // after an error, drop characters until the last one
                if (first_err == ERR_OK)
                begin
                    absorb_char(char_code);
                end
                if (is_last)
                begin
                    close_string(want);
                    due_numbers.insert(due_numbers.size(), want);
                end
            end
        end
        results_due = due_numbers.size();
    end

endmodule

/* verif/ascii_integer_parser_core_tb.sv */
`timescale 1ns / 1ps

module ascii_integer_parser_core_tb;

    import aip_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef logic [7:0] text_t[$];

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_ready;
    logic [7:0]  char_code;
    logic        is_last;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] value;
    logic [1:0]  error_code;

    int fail_count;
    int results_due;
    int results_checked;
    int send_idle_pct = 18;
    int recv_idle_pct = 73;
    int chars_sent    = 0;
    int strings_sent  = 0;

    ascii_integer_parser_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .error_code   (error_code)
    );

    aip_number_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_valid      (char_valid),
        .char_ready      (char_ready),
        .char_code       (char_code),
        .is_last         (is_last),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .value           (value),
        .error_code      (error_code),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when no word moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((char_valid && char_ready) || (result_valid && result_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $error("no word accepted for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_NL;
            default: return CH_CR;
        endcase
    endfunction

    function automatic text_t to_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
        begin
            t.insert(t.size(), s[i]);
        end
        return t;
    endfunction

    // Number text: blanks, sign, prefix, digits near or past the limits, suffix; digits are sometimes left out
    function automatic text_t number_text();
        text_t       t;
        logic        neg;
        int          radix_pick;
        logic [7:0]  sfx;
        logic [63:0] f;
        logic [63:0] lim;
        logic [63:0] mag;
        string       digits;
        logic [7:0]  c;
        neg = 1'b0;
        sfx = 8'd0;
        f   = 64'd1;
        repeat ($urandom_range(2)) t.insert(t.size(), blank_char());
        case ($urandom_range(3))
            1:
            begin
                t.insert(t.size(), CH_PLUS);
            end
            2:
            begin
                neg = 1'b1;
                t.insert(t.size(), CH_MINUS);
            end
            default:
            begin
            end
        endcase
        radix_pick = $urandom_range(9);
        if ((radix_pick < 6) && ($urandom_range(2) == 0))
        begin
            case ($urandom_range(5))
                0:
                begin
                    sfx = CH_KI;
                    f   = 64'(F_KI);
                end
                1:
                begin
                    sfx = CH_K;
                    f   = 64'(F_K);
                end
                2:
                begin
                    sfx = CH_MI;
                    f   = 64'(F_MI);
                end
                3:
                begin
                    sfx = CH_M;
                    f   = 64'(F_M);
                end
                4:
                begin
                    sfx = CH_GI;
                    f   = 64'(F_GI);
                end
                default:
                begin
                    sfx = CH_G;
                    f   = 64'(F_G);
                end
            endcase
        end
        lim = (neg ? MAX_NEG : MAX_POS) / f;
        case ($urandom_range(4))
            0:       mag = 64'($urandom_range(999));
            1:       mag = 64'($urandom) % (lim + 64'd1);
            2:       mag = lim * 64'($urandom_range(40, 2));
            default: mag = lim + 64'($urandom_range(2)) - 64'd1;
        endcase
        if (radix_pick >= 8)
        begin
            t.insert(t.size(), CH_0);
            t.insert(t.size(), CH_X);
            digits = $sformatf("%0h", mag);
        end
        else if (radix_pick >= 6)
        begin
            t.insert(t.size(), CH_0);
            digits = $sformatf("%0o", mag);
        end
        else
        begin
            digits = $sformatf("%0d", mag);
        end
        // now and then leave out the digits entirely
        if ($urandom_range(19) == 0)
        begin
            digits = "";
        end
        for (int i = 0; i < digits.len(); i++)
        begin
            c = digits[i];
            if ((c >= CH_LA) && ($urandom_range(1) == 1))
            begin
                c = c - 8'd32;
            end
            t.insert(t.size(), c);
        end
        if (sfx != 8'd0)
        begin
            t.insert(t.size(), sfx);
        end
        repeat ($urandom_range(2)) t.insert(t.size(), blank_char());
        return t;
    endfunction

    // Same as a number, with one character replaced or one inserted
    function automatic text_t broken_text();
        text_t t;
        string pool;
        int    p;
        pool = "xXkKmMgG+-09afz";
        t = number_text();
        if (t.size() == 0)
        begin
            t.insert(t.size(), CH_0);
        end
        p = $urandom_range(t.size() - 1);
        case ($urandom_range(2))
            0:       t[p] = 8'($urandom_range(255));
            1:       t.insert(p, blank_char());
            default: t[p] = pool[$urandom_range(pool.len() - 1)];
        endcase
        return t;
    endfunction

    function automatic text_t noise_text();
        text_t t;
        string pool;
        pool = "0123456789abcdefABCDEFxXkKmMgG+- ";
        repeat ($urandom_range(6, 1))
        begin
            if ($urandom_range(1) == 1)
            begin
                t.insert(t.size(), 8'($urandom_range(255)));
            end
            else
            begin
                t.insert(t.size(), pool[$urandom_range(pool.len() - 1)]);
            end
        end
        return t;
    endfunction

    function automatic text_t make_text();
        text_t t;
        int    kind;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            t = number_text();
        end
        else if (kind < 85)
        begin
            t = broken_text();
        end
        else
        begin
            t = noise_text();
        end
        if (t.size() == 0)
        begin
            t.insert(t.size(), blank_char());
        end
        return t;
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            char_code  <= 8'($urandom_range(255));
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        is_last    <= last;
        @(negedge clk);
        while (!char_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input text_t t);
        for (int i = 0; i < t.size(); i++)
        begin
            send_char(t[i], i == (t.size() - 1));
        end
        strings_sent++;
    endtask

    // Drop valid and hold off until every owed number has come out
    task automatic drain_results();
        char_valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin
        text_t one_byte;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_code  = 8'd0;
        is_last    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Corner strings: lone blank, bare suffix, lone zero, empty hex body,
        // lone sign, high code, upper-case X, blank after sign, suffix overflow,
        // most negative value, inner blank, mixed-case hex
        send_text(to_text(" "));
        send_text(to_text("k"));
        send_text(to_text("0"));
        send_text(to_text("0x"));
        send_text(to_text("-"));
        one_byte = {8'hFF};
        send_text(one_byte);
        send_text(to_text("0X"));
        send_text(to_text("+ 1"));
        send_text(to_text("7G"));
        send_text(to_text("-2g"));
        send_text(to_text("1 2"));
        send_text(to_text("0xfF"));

        while (chars_sent < 270)
        begin
            send_text(make_text());
        end
        drain_results();
        send_idle_pct <= 73;
        recv_idle_pct <= 18;
        while (chars_sent < 540)
        begin
            send_text(make_text());
        end
        drain_results();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        while (chars_sent < 800)
        begin
            send_text(make_text());
        end
        drain_results();
        repeat (12) @(posedge clk);

        $display("Sent %0d characters in %0d strings under three idle profiles.",
                 chars_sent, strings_sent);
        $display("Compared %0d numbers: decimal, octal, hex, suffixes, range edges, bad text.",
                 results_checked);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
